[rtl/skpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpq_pkg: shared types and constants of the sorted-key priority queue
// Beat structs, operation and status codes, controller command struct.
// ----------------------------------------------------------------------------
package skpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // operation codes
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_PREPEND = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request beat
    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] new_key;
        logic [DATA_W-1:0]       item_data;
    } skpq_req_t;

    // result beat
    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] head_key;
        logic [DATA_W-1:0]       head_data;
        logic [COUNT_OUT_W-1:0]  count_after;
    } skpq_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture request beat
        logic calc;    // compare all cells, form prepend key
        logic update;  // shift cells, update count, register result
    } skpq_cmd_t;

endpackage

[rtl/skpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpq_ctrl: operation sequencer
// Steps each accepted request through capture, compare and update, and
// raises the result strobe for one cycle after the update.
// ----------------------------------------------------------------------------
module skpq_ctrl
    import skpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output skpq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CALC   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // commands and status
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.calc   = (state_reg == S_CALC);
    assign cmd.update = (state_reg == S_UPDATE);

endmodule

[rtl/skpq_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpq_dpath: sorted cell array and result register
// A row of key/data cells kept in ascending key order. Each cell compares
// itself against the new key; the update shifts cells up or down in place.
// ----------------------------------------------------------------------------
module skpq_dpath
    import skpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  skpq_cmd_t cmd,
    input  skpq_req_t request,
    output skpq_rsp_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // captured request
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;

    // cell row
    logic [KEY_W-1:0]  key_cells_reg  [CAPACITY];
    logic [KEY_W-1:0]  key_cells_next [CAPACITY];
    logic [DATA_W-1:0] data_cells_reg [CAPACITY];
    logic [DATA_W-1:0] data_cells_next[CAPACITY];

    // per-cell "new entry goes after this cell" flags
    logic [CAPACITY-1:0] after_reg, after_next;
    logic [KEY_W-1:0]    pre_key_reg, pre_key_next;

    logic [CNT_W-1:0] count_reg, count_next;
    skpq_rsp_t        result_reg, result_next;

    logic                is_full, is_empty;
    logic [CAPACITY-1:0] eff_after;
    logic [KEY_W-1:0]    ins_key;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // compare stage: every valid cell against the new key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                after_next[i] = (CNT_W'(i) < count_reg) &&
                                !($signed(key_reg) < $signed(key_cells_reg[i]));
            end
            else
            begin
                after_next[i] = (CNT_W'(i) < count_reg) &&
                                ($signed(key_cells_reg[i]) < $signed(key_reg));
            end
        end
        if (is_empty)
        begin
            pre_key_next = '0;
        end
        else if (key_cells_reg[0] == KEY_MIN)
        begin
            pre_key_next = KEY_MIN;
        end
        else
        begin
            pre_key_next = key_cells_reg[0] - 1'b1;
        end
    end

    // update stage: cell moves, count and result
    always_comb
    begin
        eff_after = (op_reg == OP_INSERT) ? after_reg : '0;
        ins_key   = (op_reg == OP_INSERT) ? key_reg : pre_key_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_cells_next[i]  = key_cells_reg[i];
            data_cells_next[i] = data_cells_reg[i];
        end
        count_next              = count_reg;
        result_next.status      = ST_OK;
        result_next.head_key    = '0;
        result_next.head_data   = '0;

        case (op_reg) inside
            OP_INSERT, OP_PREPEND:
            begin
                if (is_full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (eff_after[i])
                        begin
                            key_cells_next[i]  = key_cells_reg[i];
                            data_cells_next[i] = data_cells_reg[i];
                        end
                        else if (i == 0 || eff_after[(i == 0) ? 0 : i - 1])
                        begin
                            key_cells_next[i]  = ins_key;
                            data_cells_next[i] = data_reg;
                        end
                        else
                        begin
                            key_cells_next[i]  = key_cells_reg[(i == 0) ? 0 : i - 1];
                            data_cells_next[i] = data_cells_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (is_empty)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    result_next.head_key  = key_cells_reg[0];
                    result_next.head_data = data_cells_reg[0];
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        key_cells_next[i] =
                            key_cells_reg[(i == CAPACITY - 1) ? i : i + 1];
                        data_cells_next[i] =
                            data_cells_reg[(i == CAPACITY - 1) ? i : i + 1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase

        count_ext               = {{COUNT_OUT_W{1'b0}}, count_next};
        result_next.count_after = count_ext[COUNT_OUT_W-1:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= request.op;
            key_reg  <= request.new_key;
            data_reg <= request.item_data;
        end
        if (cmd.calc)
        begin
            after_reg   <= after_next;
            pre_key_reg <= pre_key_next;
        end
        if (cmd.update)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                key_cells_reg[i]  <= key_cells_next[i];
                data_cells_reg[i] <= data_cells_next[i];
            end
            result_reg <= result_next;
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    assign result = result_reg;

    // count stays within capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // refused add leaves the count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && is_full && (op_reg == OP_INSERT || op_reg == OP_PREPEND)
        |=> $stable(count_reg))
        else $error("count changed on refused add");

    // remove from non-empty queue drops exactly one entry
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && (op_reg == OP_REMOVE) && !is_empty
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not drop one entry");

    // insert flags form a prefix of the valid cells
    a_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && (op_reg == OP_INSERT)
        |-> ((after_reg & (after_reg + 1'b1)) == '0))
        else $error("insert position flags not contiguous");

endmodule

[rtl/sorted_key_priority_queue_core.sv]
`timescale 1ns / 1ps
// Each request runs through the capture, compare and shift steps of the
// sequencer over the cell row; done then strobes with the registered result.
// A new request is taken only when the sequencer is idle again (busy low).
// Reset: rst_n clears the entry count and sequencer at once; cell contents
// stay undefined. The receiver cannot stall: done strobes for one cycle.
// ----------------------------------------------------------------------------
// sorted_key_priority_queue_core: bounded sorted-key priority queue
// Insert, prepend, remove-head and clear over a row of sorted cells.
// ----------------------------------------------------------------------------
module sorted_key_priority_queue_core
    import skpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  skpq_req_t request,
    output logic      done,
    output skpq_rsp_t result
);

    skpq_cmd_t cmd;

    // sequencer
    skpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // cell row and result
    skpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule
